>>> rtl/ngga_pkg.sv
// Shared types and constants for the GGA sentence parser.
// No dependencies; the datapath, controller, top level and testbench import this package.
`default_nettype none

package ngga_pkg;

  // Longest latitude or longitude field that is kept, in characters.
  localparam int unsigned FIELD_MAX = 16;
  localparam int unsigned IDX_W     = $clog2(FIELD_MAX);
  localparam int unsigned LEN_W     = $clog2(FIELD_MAX + 1);

  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] MAX_LEN_RESET = 7'd80;
  localparam logic [POS_W-1:0] ADDR_LEN      = 7'd5;
  localparam logic [POS_W-1:0] HDR_MIN_LEN   = 7'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [3:0] COMMA_SAT = 4'hF;
  localparam logic [3:0] LAT_FIELD = 4'd2;
  localparam logic [3:0] LON_FIELD = 4'd4;

  typedef enum logic [1:0] {
    KIND_LAT    = 2'd0,
    KIND_LON    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_WRONG_TYPE = 2'd1,
    ST_BAD_SUM    = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_e;

  // Parser phase inside the datapath.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_BODY   = 5'b00010,
    PH_CK1    = 5'b00100,
    PH_CK2    = 5'b01000,
    PH_CK2BAD = 5'b10000
  } phase_e;

  // Sequencer state of the controller.
  typedef enum logic [5:0] {
    CS_ACCEPT  = 6'b000001,
    CS_LAT_RD  = 6'b000010,
    CS_LAT_OUT = 6'b000100,
    CS_LON_RD  = 6'b001000,
    CS_LON_OUT = 6'b010000,
    CS_STATUS  = 6'b100000
  } ctrl_state_e;

  // What the output register loads in a cycle.
  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_LAT     = 3'd1,
    OUT_LON     = 3'd2,
    OUT_END_NOW = 3'd3,
    OUT_END_OK  = 3'd4
  } out_sel_e;

  typedef struct packed {
    logic     take;
    logic     lat_re;
    logic     lon_re;
    logic     idx_clr;
    logic     idx_inc;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic sent_end;
    logic sent_ok;
    logic lat_done;
    logic lon_done;
  } dp_stat_t;

  // Expected address field text "GPGGA".
  function automatic logic [7:0] addr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h47;
      default: c = 8'h41;
    endcase
    return c;
  endfunction

  // Upper-case hex digit decode; bit 4 is set for a legal digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ngga_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ngga_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ngga_dp.sv
// Datapath of the GGA parser: sentence parse registers, field buffers,
// output register and the length register. Depends on ngga_pkg, ngga_ram.
`default_nettype none

module ngga_dp (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [7:0]        rx_byte_i,
  input  wire               cfg_we_i,
  input  wire  [6:0]        cfg_data_i,
  input  wire               out_stall_i,
  input  ngga_pkg::dp_cmd_t cmd_i,
  output ngga_pkg::dp_stat_t stat_o,
  output logic              out_valid_o,
  output logic [1:0]        item_kind_o,
  output logic [7:0]        char_value_o,
  output logic [1:0]        sentence_status_o,
  output logic              last_of_run_o
);
  import ngga_pkg::*;

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [3:0]        comma_q, comma_d;
  logic              hdr_q, hdr_d;
  logic [7:0]        xor_q, xor_d;
  logic [3:0]        hi_q, hi_d;
  logic [LEN_W-1:0]  lat_len_q, lat_len_d;
  logic [LEN_W-1:0]  lon_len_q, lon_len_d;
  logic [LEN_W-1:0]  idx_q;
  logic [POS_W-1:0]  max_len_q;

  logic              out_valid_q;
  kind_e             kind_q;
  logic [7:0]        char_q;
  status_e           st_q;
  logic              last_q;

  logic              lat_we, lon_we;
  logic [7:0]        lat_rdata, lon_rdata;
  logic [4:0]        hex;
  status_e           st_now;

  assign hex = hex_decode(rx_byte_i);

  // Status of the sentence if the current byte ends it.
  always_comb begin
    if (phase_q == PH_BODY) begin
      st_now = ST_TOO_LONG;
    end else if (!hdr_q) begin
      st_now = ST_WRONG_TYPE;
    end else if (phase_q == PH_CK2BAD || !hex[4] || {hi_q, hex[3:0]} != xor_q) begin
      st_now = ST_BAD_SUM;
    end else begin
      st_now = ST_VALID;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    comma_d   = comma_q;
    hdr_d     = hdr_q;
    xor_d     = xor_q;
    hi_d      = hi_q;
    lat_len_d = lat_len_q;
    lon_len_d = lon_len_q;
    lat_we    = 1'b0;
    lon_we    = 1'b0;
    if (cmd_i.take) begin
      if (rx_byte_i == CH_DOLLAR) begin
        phase_d   = PH_BODY;
        pos_d     = '0;
        comma_d   = '0;
        hdr_d     = 1'b1;
        xor_d     = '0;
        hi_d      = '0;
        lat_len_d = '0;
        lon_len_d = '0;
      end else begin
        unique case (phase_q)
          PH_BODY: begin
            if (rx_byte_i == CH_STAR) begin
              if (pos_q < HDR_MIN_LEN) hdr_d = 1'b0;
              phase_d = PH_CK1;
            end else if (pos_q >= max_len_q) begin
              phase_d = PH_IDLE;
            end else begin
              xor_d = xor_q ^ rx_byte_i;
              if (pos_q < ADDR_LEN && rx_byte_i != addr_char(pos_q[2:0])) hdr_d = 1'b0;
              if (pos_q == ADDR_LEN && rx_byte_i != CH_COMMA) hdr_d = 1'b0;
              if (rx_byte_i == CH_COMMA) begin
                if (comma_q != COMMA_SAT) comma_d = comma_q + 4'd1;
              end else if (comma_q == LAT_FIELD) begin
                if (lat_len_q < LEN_W'(FIELD_MAX)) begin
                  lat_we    = 1'b1;
                  lat_len_d = lat_len_q + LEN_W'(1);
                end
              end else if (comma_q == LON_FIELD) begin
                if (lon_len_q < LEN_W'(FIELD_MAX)) begin
                  lon_we    = 1'b1;
                  lon_len_d = lon_len_q + LEN_W'(1);
                end
              end
              pos_d = pos_q + POS_W'(1);
            end
          end
          PH_CK1: begin
            hi_d    = hex[3:0];
            phase_d = hex[4] ? PH_CK2 : PH_CK2BAD;
          end
          PH_CK2, PH_CK2BAD: begin
            phase_d = PH_IDLE;
          end
          PH_IDLE: begin
            phase_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= '0;
      comma_q   <= '0;
      hdr_q     <= 1'b0;
      xor_q     <= '0;
      hi_q      <= '0;
      lat_len_q <= '0;
      lon_len_q <= '0;
      max_len_q <= MAX_LEN_RESET;
      idx_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      comma_q   <= comma_d;
      hdr_q     <= hdr_d;
      xor_q     <= xor_d;
      hi_q      <= hi_d;
      lat_len_q <= lat_len_d;
      lon_len_q <= lon_len_d;
      if (cfg_we_i) max_len_q <= cfg_data_i;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + LEN_W'(1);
      end
    end
  end

  ngga_ram #(.WIDTH(8), .DEPTH(FIELD_MAX)) u_lat_ram (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .waddr_i (lat_len_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.lat_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (lat_rdata)
  );

  ngga_ram #(.WIDTH(8), .DEPTH(FIELD_MAX)) u_lon_ram (
    .clk_i   (clk_i),
    .we_i    (lon_we),
    .waddr_i (lon_len_q[IDX_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.lon_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (lon_rdata)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_sel != OUT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.out_sel)
      OUT_LAT: begin
        kind_q <= KIND_LAT;
        char_q <= lat_rdata;
        st_q   <= ST_VALID;
        last_q <= 1'b0;
      end
      OUT_LON: begin
        kind_q <= KIND_LON;
        char_q <= lon_rdata;
        st_q   <= ST_VALID;
        last_q <= 1'b0;
      end
      OUT_END_NOW: begin
        kind_q <= KIND_STATUS;
        char_q <= '0;
        st_q   <= st_now;
        last_q <= 1'b1;
      end
      OUT_END_OK: begin
        kind_q <= KIND_STATUS;
        char_q <= '0;
        st_q   <= ST_VALID;
        last_q <= 1'b1;
      end
      default: begin
        kind_q <= kind_q;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign item_kind_o       = kind_q;
  assign char_value_o      = char_q;
  assign sentence_status_o = st_q;
  assign last_of_run_o     = last_q;

  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.sent_end  = (rx_byte_i != CH_DOLLAR) &&
                            ((phase_q == PH_BODY && rx_byte_i != CH_STAR &&
                              pos_q >= max_len_q) ||
                             phase_q == PH_CK2 || phase_q == PH_CK2BAD);
  assign stat_o.sent_ok   = (phase_q != PH_BODY) && (st_now == ST_VALID);
  assign stat_o.lat_done  = (idx_q == lat_len_q);
  assign stat_o.lon_done  = (idx_q == lon_len_q);

endmodule

`default_nettype wire

>>> rtl/ngga_ctrl.sv
// Controller of the GGA parser: input handshake and the sequencer that
// replays buffered fields after a valid sentence. Depends on ngga_pkg.
`default_nettype none

module ngga_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  ngga_pkg::dp_stat_t stat_i,
  output ngga_pkg::dp_cmd_t  cmd_o
);
  import ngga_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        take;

  assign in_stall_o = !(state_q == CS_ACCEPT && stat_i.slot_free);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.take    = take;
    cmd_o.out_sel = OUT_NONE;
    unique case (state_q)
      CS_ACCEPT: begin
        if (take && stat_i.sent_end) begin
          if (stat_i.sent_ok) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = CS_LAT_RD;
          end else begin
            cmd_o.out_sel = OUT_END_NOW;
          end
        end
      end
      CS_LAT_RD: begin
        if (stat_i.lat_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = CS_LON_RD;
        end else begin
          cmd_o.lat_re = 1'b1;
          state_d      = CS_LAT_OUT;
        end
      end
      CS_LAT_OUT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_sel = OUT_LAT;
          cmd_o.idx_inc = 1'b1;
          state_d       = CS_LAT_RD;
        end
      end
      CS_LON_RD: begin
        if (stat_i.lon_done) begin
          state_d = CS_STATUS;
        end else begin
          cmd_o.lon_re = 1'b1;
          state_d      = CS_LON_OUT;
        end
      end
      CS_LON_OUT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_sel = OUT_LON;
          cmd_o.idx_inc = 1'b1;
          state_d       = CS_LON_RD;
        end
      end
      CS_STATUS: begin
        if (stat_i.slot_free) begin
          cmd_o.out_sel = OUT_END_OK;
          state_d       = CS_ACCEPT;
        end
      end
      default: begin
        state_d = CS_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nmea_gga_position_parser_unit.sv
// GGA sentence parser top level: controller plus datapath. Depends on
// ngga_pkg, ngga_ctrl, ngga_dp and ngga_ram.
// Throughput: one byte a cycle while the output register is free; a byte that
// ends a sentence badly gives its status item in the next cycle.
// A valid sentence end stalls the input while each buffered character is replayed
// (registered RAM read, then output load) and through the end checks and status.
// Reset (rst_ni low, asynchronous) returns to idle with a length limit of 80.
`default_nettype none

module nmea_gga_position_parser_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  rx_byte_i,
  input  wire         cfg_we_i,
  input  wire  [6:0]  cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  char_value_o,
  output logic [1:0]  sentence_status_o,
  output logic        last_of_run_o
);
  import ngga_pkg::*;

  // The controller owns the handshake and the replay sequencer; the
  // datapath owns the parse registers, both field buffers and the output
  // register. They talk only through the command and status structs.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ngga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ngga_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_byte_i         (rx_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .item_kind_o       (item_kind_o),
    .char_value_o      (char_value_o),
    .sentence_status_o (sentence_status_o),
    .last_of_run_o     (last_of_run_o)
  );

`ifndef SYNTH
  // While a replay burst is in flight, no new byte may be taken.
  a_no_take_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("byte accepted during field replay");

  // Only the status item closes a run.
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_run_o == (item_kind_o == KIND_STATUS)))
    else $error("last flag does not match item kind");

  // Field characters come only from valid sentences; status carries no char.
  a_payload_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (item_kind_o == KIND_STATUS) ? (char_value_o == 8'd0)
                                                 : (sentence_status_o == ST_VALID))
    else $error("malformed result item");
`endif

endmodule

`default_nettype wire

>>> bench/nmea_gga_position_parser_unit_test.sv
// Self-checking testbench for the GGA sentence parser top level.
// Drives bytes and length limits, predicts every result item in a scoreboard
// class and compares them field by field. Depends only on ngga_pkg and the RTL.
`timescale 1ns / 100ps

module nmea_gga_position_parser_unit_test;
  import ngga_pkg::*;

  // Clock period is 2 ns. A correct run with every gap and stall at its longest
  // stays far below a quarter of this limit.
  localparam int RUN_LIMIT_NS = 400_000;
  // A byte that ends no sentence is finished in the next cycle, and the status
  // of a valid sentence follows once its buffered characters are replayed. This
  // margin covers both before the length limit is touched or the run ends.
  localparam int SETTLE_CYCLES = 20;

  localparam logic [39:0] GGA_ADDR = "GPGGA";
  localparam logic [7:0]  CH_DIGIT_0 = 8'h30;
  localparam logic [7:0]  CH_UPPER_A = 8'h41;
  localparam logic [7:0]  CH_LOWER_A = 8'h61;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    status_e    status;
    logic       last;
  } gga_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       cfg_we_i;
  logic [6:0] cfg_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] item_kind_o;
  logic [7:0] char_value_o;
  logic [1:0] sentence_status_o;
  logic       last_of_run_o;

  // Character i of the address field text.
  function automatic logic [7:0] addr_byte(input int i);
    return GGA_ADDR[8*(4-i) +: 8];
  endfunction

  // Mirrors the parser: it follows each accepted byte through the sentence
  // and queues the result items that the byte must cause.
  class gga_parse_scoreboard;
    phase_e      phase;
    logic [6:0]  limit;
    logic [6:0]  pos;
    logic [3:0]  commas;
    logic        hdr_ok;
    logic [7:0]  csum;
    logic [3:0]  hi_nib;
    logic [7:0]  lat_chars[$];
    logic [7:0]  lon_chars[$];
    gga_result_t due_items[$];
    int          errors;
    int          n_bytes;
    int          n_results;
    int          status_seen[4];

    function new();
      phase  = PH_IDLE;
      limit  = MAX_LEN_RESET;
      pos    = '0;
      commas = '0;
      hdr_ok = 1'b0;
      csum   = '0;
      hi_nib = '0;
      errors = 0;
      n_bytes = 0;
      n_results = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(input logic [6:0] v);
      limit = v;
    endfunction

    function int pending();
      return due_items.size();
    endfunction

    function int hex_value(input logic [7:0] c);
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 8'd9) return int'(c - CH_DIGIT_0);
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
      return -1;
    endfunction

    function void add_result(input kind_e k, input logic [7:0] v, input status_e s,
                             input logic l);
      gga_result_t r;
      r.kind   = k;
      r.value  = v;
      r.status = s;
      r.last   = l;
      due_items.push_back(r);
      if (k == KIND_STATUS) status_seen[s]++;
    endfunction

    function void take_byte(input logic [7:0] b);
      int         d;
      status_e    st;
      logic [7:0] got_sum;
      n_bytes++;
      if (b == CH_DOLLAR) begin
        phase  = PH_BODY;
        pos    = '0;
        commas = '0;
        hdr_ok = 1'b1;
        csum   = '0;
        hi_nib = '0;
        lat_chars.delete();
        lon_chars.delete();
        return;
      end
      case (phase)
        PH_BODY: begin
          if (b == CH_STAR) begin
            if (pos < HDR_MIN_LEN) hdr_ok = 1'b0;
            phase = PH_CK1;
          end else if (pos >= limit) begin
            phase = PH_IDLE;
            add_result(KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1);
          end else begin
            csum = csum ^ b;
            if (pos < ADDR_LEN) begin
              if (b != addr_byte(int'(pos))) hdr_ok = 1'b0;
            end else if (pos == ADDR_LEN && b != CH_COMMA) begin
              hdr_ok = 1'b0;
            end
            if (b == CH_COMMA) begin
              if (commas != COMMA_SAT) commas++;
            end else if (commas == LAT_FIELD) begin
              if (lat_chars.size() < FIELD_MAX) lat_chars.push_back(b);
            end else if (commas == LON_FIELD) begin
              if (lon_chars.size() < FIELD_MAX) lon_chars.push_back(b);
            end
            pos++;
          end
        end
        PH_CK1: begin
          d = hex_value(b);
          if (d < 0) begin
            phase = PH_CK2BAD;
          end else begin
            hi_nib = d[3:0];
            phase  = PH_CK2;
          end
        end
        PH_CK2, PH_CK2BAD: begin
          d = hex_value(b);
          got_sum = {hi_nib, d[3:0]};
          if (!hdr_ok) begin
            st = ST_WRONG_TYPE;
          end else if (phase == PH_CK2BAD || d < 0 || got_sum != csum) begin
            st = ST_BAD_SUM;
          end else begin
            st = ST_VALID;
          end
          phase = PH_IDLE;
          if (st == ST_VALID) begin
            foreach (lat_chars[i]) add_result(KIND_LAT, lat_chars[i], ST_VALID, 1'b0);
            foreach (lon_chars[i]) add_result(KIND_LON, lon_chars[i], ST_VALID, 1'b0);
          end
          add_result(KIND_STATUS, 8'h00, st, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_item(input logic [1:0] kind, input logic [7:0] value,
                             input logic [1:0] status, input logic last);
      gga_result_t want;
      n_results++;
      if (due_items.size() == 0) begin
        $error("unexpected item: kind %0d, char %02h, status %0d, last %0b",
               kind, value, status, last);
        errors++;
        return;
      end
      want = due_items.pop_front();
      if (kind !== want.kind) begin
        $error("item_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $error("char_value: expected %02h, actual %02h", want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $error("sentence_status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  gga_parse_scoreboard sb;

  logic [7:0] tx_q[$];    // bytes of the sentence being built
  int         sent_bytes; // sentence bytes sent, noise not included
  logic       in_idle_on;
  logic       out_idle_on;

  nmea_gga_position_parser_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_kind_o       (item_kind_o),
    .char_value_o      (char_value_o),
    .sentence_status_o (sentence_status_o),
    .last_of_run_o     (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the rising edge, where every signal still
  // holds the value that the block itself saw, so the order of processes
  // within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_item(item_kind_o, char_value_o, sentence_status_o, last_of_run_o);
      end
    end
  end

  // The receiver holds off in random bursts, with quiet stretches between
  // them, so that stalls land on characters as well as on status items.
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("nmea_gga_position_parser_unit_test NOT OK");
    $finish;
  end

  // Offers one byte and returns at the edge that takes it. Valid stays high
  // from one byte to the next unless a gap is inserted.
  task automatic send_byte(input logic [7:0] b);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_queue(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(tx_q[i]);
      sent_bytes++;
    end
  endtask

  // Waits until every predicted item has come out and the parser has had
  // time to finish bytes that cause none. The first edge lets the monitor
  // record the byte taken at the edge on which this task was called.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [6:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_DIGIT_0 + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
  endfunction

  // Any byte other than a dollar sign, a star or a comma.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
    return b;
  endfunction

  function automatic void add_field(input int n, input logic plain);
    string digits;
    digits = "0123456789.";
    for (int i = 0; i < n; i++) begin
      if (plain || $urandom_range(0, 3) != 0) tx_q.push_back(digits[$urandom_range(0, 10)]);
      else tx_q.push_back(text_byte());
    end
  endfunction

  // Most fields are short; a few run past the field buffer so it truncates.
  function automatic int field_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
  endfunction

  // Appends the star and two checksum digits for the given sum, normally the XOR
  // of everything after the most recent dollar sign.
  function automatic void add_checksum(input logic [7:0] sum);
    tx_q.push_back(CH_STAR);
    tx_q.push_back(hex_char(sum[7:4]));
    tx_q.push_back(hex_char(sum[3:0]));
  endfunction

  function automatic logic [7:0] body_xor();
    logic [7:0] x;
    x = '0;
    foreach (tx_q[i]) x = (tx_q[i] == CH_DOLLAR) ? 8'h00 : x ^ tx_q[i];
    return x;
  endfunction

  // Builds one sentence. Most are well-formed GGA sentences with random
  // field content; the rest carry a damaged address, a wrong or malformed
  // checksum, or so many fields that the comma counter saturates.
  function automatic void build_sentence();
    int         shape;
    int         n;
    int         ck;
    logic [7:0] sum;
    logic [7:0] b;
    tx_q.delete();
    tx_q.push_back(CH_DOLLAR);
    shape = $urandom_range(0, 19);
    if (shape == 17) begin
      // Short address: the star arrives before the address and its comma.
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) tx_q.push_back(addr_byte(i));
    end else begin
      for (int i = 0; i < 5; i++) tx_q.push_back(addr_byte(i));
      if (shape == 16) tx_q[$urandom_range(1, 5)] = text_byte();
      if (shape == 18) tx_q.push_back(addr_byte(4));
      if (shape == 19) tx_q[5] = CH_COMMA;
      tx_q.push_back(CH_COMMA);
      add_field($urandom_range(0, 6), 1'b1);
      tx_q.push_back(CH_COMMA);
      add_field(field_len(), 1'b0);
      tx_q.push_back(CH_COMMA);
      add_text($urandom_range(0, 1) ? "N" : "S");
      tx_q.push_back(CH_COMMA);
      add_field(field_len(), 1'b0);
      tx_q.push_back(CH_COMMA);
      add_text($urandom_range(0, 1) ? "E" : "W");
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        tx_q.push_back(CH_COMMA);
        add_field($urandom_range(0, 2), 1'b0);
      end
    end
    sum = body_xor();
    ck  = $urandom_range(0, 15);
    if (ck == 12) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    add_checksum(sum);
    if (ck == 13 || ck == 14) begin
      do b = text_byte(); while (sb.hex_value(b) >= 0);
      tx_q[tx_q.size() - (ck == 13 ? 2 : 1)] = b;
    end else if (ck == 15) begin
      // Lower-case hex letters are not accepted as checksum digits.
      for (int i = tx_q.size() - 2; i < tx_q.size(); i++) begin
        if (tx_q[i] >= CH_UPPER_A) tx_q[i] = tx_q[i] - CH_UPPER_A + CH_LOWER_A;
      end
    end
  endfunction

  // One stretch of random traffic under a given length limit. Now and then
  // a sentence is cut short, and a few stray bytes come between sentences.
  task automatic run_phase(input logic [6:0] lim, input int count, input logic idle);
    int         goal;
    logic [7:0] b;
    drain();
    write_limit(lim);
    in_idle_on  = idle;
    out_idle_on = idle;
    goal = sent_bytes + count;
    while (sent_bytes < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR);
          send_byte(b);
        end
      end
      build_sentence();
      if ($urandom_range(0, 9) == 0) send_queue($urandom_range(1, tx_q.size() - 1));
      else send_queue(tx_q.size());
    end
  endtask

  initial begin
    sb = new();
    sent_bytes  = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= 7'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset limit. A stray byte while idle is
    // ignored, and a dollar sign inside an address restarts the sentence.
    // The valid sentence that follows carries the byte extremes 0xFF and
    // 0x00 as its latitude and longitude. Then a short address whose
    // checksum is also wrong, which must be reported as the wrong type, and
    // a well-formed address with a non-hex checksum digit.
    tx_q.delete();
    add_text("x$GP$GPGGA,,");
    tx_q.push_back(8'hFF);
    add_text(",,");
    tx_q.push_back(8'h00);
    add_checksum(body_xor());
    add_text("$G*00$GPGGA,*Z0");
    send_queue(tx_q.size());

    // Random part across several limits, among them the largest, 127, and a
    // small one, 8. The last phase runs with no gaps and no stalls at all.
    run_phase(7'd127, 85, 1'b1);
    run_phase(7'd8, 40, 1'b1);
    run_phase(7'($urandom_range(9, 126)), 75, 1'b1);
    run_phase(7'($urandom_range(20, 40)), 70, 1'b1);
    run_phase(MAX_LEN_RESET, 60, 1'b0);
    drain();

    $display("Sent %0d bytes and checked %0d items under limits 80, 127, 8 and random.",
             sb.n_bytes, sb.n_results);
    $display("Sentence ends: %0d valid, %0d wrong type, %0d bad checksum, %0d too long.",
             sb.status_seen[ST_VALID], sb.status_seen[ST_WRONG_TYPE],
             sb.status_seen[ST_BAD_SUM], sb.status_seen[ST_TOO_LONG]);
    if (sb.errors == 0) begin
      $display("nmea_gga_position_parser_unit_test OK");
    end else begin
      $display("nmea_gga_position_parser_unit_test NOT OK");
    end
    $finish;
  end

endmodule
